/* design/swmf_pkg.sv */
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants for the sliding window maximum filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

    // window_size register
    localparam int             WS_BITS          = 7;
    localparam logic [6:0]     WS_RESET         = 7'd3;

    // register map
    localparam int             ADDR_BITS        = 3;
    localparam logic [2:0]     ADDR_WINDOW_SIZE = 3'd0;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // broadcast to every cell of the candidate chain
    typedef struct packed {
        logic inc;   // age all candidates by one
        logic clr;   // start marker: drop all candidates
        logic sh;    // oldest candidate leaves, chain moves one place forward
        logic fin;   // pop candidates <= sample and insert the sample
    } cell_ctrl_t;

endpackage

/* design/sliding_window_max_filter.sv */
// ----------------------------------------------------------------------------
// sliding_window_max_filter
// Running maximum over the last window_size samples, kept as a chain of
// candidate cells with strictly decreasing values from oldest to newest.
// ----------------------------------------------------------------------------
// Output: a result word is registered in window_max_reg and shown on window_max.
// Throughput: 1 word per cycle while out_ready does not hold a result back and at most
//   one candidate ages out per word; after window_size shrinks, input stalls while the
//   further candidates leave (the chain drops one candidate from its head per cycle).
// Reset: window_size = 3, all candidate valid bits and seen count cleared at
//   once; no clearing pass, candidate values are not reset.
module sliding_window_max_filter
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swmf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic                           first,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_BITS-1:0]  window_max
);

    localparam int AB = $clog2(MAX_WINDOW + 1);
    localparam int KB = (AB > swmf_pkg::WS_BITS) ? AB : swmf_pkg::WS_BITS;
    localparam int N  = MAX_WINDOW;

    logic [swmf_pkg::WS_BITS-1:0]  window_size;
    logic [KB-1:0]                 k;

    swmf_pkg::state_t              state_reg;
    swmf_pkg::state_t              state_next;
    swmf_pkg::cell_ctrl_t          ctrl;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [AB-1:0]                 seen_reg;
    logic [AB-1:0]                 seen_next;
    logic [AB-1:0]                 seen_base;
    logic                          pend_emit_reg;
    logic                          emit_now;
    logic                          emit;
    logic                          accept;
    logic                          active;
    logic                          expire0;
    logic                          expire1;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] window_max_reg;

    logic [N-1:0]                  cell_vld;
    logic [AB-1:0]                 cell_age  [N];
    logic signed [SAMPLE_BITS-1:0] cell_val  [N];
    logic signed [SAMPLE_BITS-1:0] cell_nval [N];
    logic [N-1:0]                  cell_surv;
    logic [N-1:0]                  cell_exp;

    swmf_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_size (window_size)
    );

    assign k = (KB'(window_size) > KB'(MAX_WINDOW)) ? KB'(MAX_WINDOW) : KB'(window_size);

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                          l_surv;
        logic                          r_vld;
        logic [AB-1:0]                 r_age;
        logic signed [SAMPLE_BITS-1:0] r_val;

        if (i == 0)
        begin : g_head
            assign l_surv = 1'b1;
        end
        else
        begin : g_body
            assign l_surv = cell_surv[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign r_vld = 1'b0;
            assign r_age = '0;
            assign r_val = '0;
        end
        else
        begin : g_link
            assign r_vld = cell_vld[i+1];
            assign r_age = cell_age[i+1];
            assign r_val = cell_val[i+1];
        end

        swmf_cell
        #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .MAX_WINDOW  (MAX_WINDOW)
        )
        u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .k          (k),
            .smp        (smp),
            .left_surv  (l_surv),
            .right_vld  (r_vld),
            .right_age  (r_age),
            .right_val  (r_val),
            .vld_o      (cell_vld[i]),
            .age_o      (cell_age[i]),
            .val_o      (cell_val[i]),
            .surv_o     (cell_surv[i]),
            .expire_o   (cell_exp[i]),
            .val_next_o (cell_nval[i])
        );
    end

    assign expire0 = cell_exp[0];
    if (N > 1)
    begin : g_exp1
        assign expire1 = cell_exp[1];
    end
    else
    begin : g_noexp1
        assign expire1 = 1'b0;
    end

    assign in_ready = (state_reg == swmf_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign active   = accept || (state_reg == swmf_pkg::ST_DRAIN);
    assign smp      = (state_reg == swmf_pkg::ST_DRAIN) ? samp_reg : sample;

    // ages only step once per word; the head may leave once per cycle
    always_comb
    begin
        ctrl.inc = accept;
        ctrl.clr = accept && first;
        ctrl.sh  = active && expire0;
        ctrl.fin = active && !(expire0 && expire1);
    end

    always_comb
    begin
        seen_base = first ? '0 : seen_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = (seen_base == AB'(MAX_WINDOW)) ? seen_base : seen_base + AB'(1);
        end
        emit_now = (k != '0) && (KB'(seen_next) >= k);
        emit     = (state_reg == swmf_pkg::ST_DRAIN) ? pend_emit_reg : emit_now;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmf_pkg::ST_IDLE:
            begin
                if (accept && !ctrl.fin)
                begin
                    state_next = swmf_pkg::ST_DRAIN;
                end
            end
            swmf_pkg::ST_DRAIN:
            begin
                if (ctrl.fin)
                begin
                    state_next = swmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.fin && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swmf_pkg::ST_IDLE;
            seen_reg      <= '0;
            pend_emit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pend_emit_reg <= emit_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg <= sample;
        end
        if (ctrl.fin && emit)
        begin
            window_max_reg <= cell_nval[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

    // candidates stay packed from the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_vld & (cell_vld + N'(1))) == '0))
        else $error("candidate chain not packed");

    // a start marker leaves just the new sample in the chain
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first) |=> (cell_vld == N'(1)))
        else $error("start marker did not clear history");

    // the output slot is free while the head is being drained
    a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swmf_pkg::ST_DRAIN) |-> !out_valid_reg)
        else $error("result pending during drain");

    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= AB'(MAX_WINDOW))
        else $error("seen count past saturation");

endmodule

/* design/swmf_cfg.sv */
// ----------------------------------------------------------------------------
// swmf_cfg
// APB register file holding the window_size register.
// ----------------------------------------------------------------------------
module swmf_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swmf_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [swmf_pkg::WS_BITS-1:0]  window_size
);

    logic [swmf_pkg::WS_BITS-1:0] ws_reg;
    logic [swmf_pkg::WS_BITS-1:0] ws_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == swmf_pkg::ADDR_WINDOW_SIZE);

    always_comb
    begin
        ws_next = ws_reg;
        if (wr_en)
        begin
            ws_next = pwdata[swmf_pkg::WS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= swmf_pkg::WS_RESET;
        end
        else
        begin
            ws_reg <= ws_next;
        end
    end

    always_comb
    begin
        if (paddr == swmf_pkg::ADDR_WINDOW_SIZE)
        begin
            prdata = {{(32-swmf_pkg::WS_BITS){1'b0}}, ws_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign window_size = ws_reg;

endmodule

/* design/swmf_cell.sv */
// ----------------------------------------------------------------------------
// swmf_cell
// One candidate slot of the monotonic chain: value, age and valid bit.
// ----------------------------------------------------------------------------
module swmf_cell
#(
    parameter int   SAMPLE_BITS = 16,
    parameter int   MAX_WINDOW  = 64,
    localparam int  AB          = $clog2(MAX_WINDOW + 1),
    localparam int  KB          = (AB > swmf_pkg::WS_BITS) ? AB : swmf_pkg::WS_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  swmf_pkg::cell_ctrl_t          ctrl,
    input  logic [KB-1:0]                 k,
    input  logic signed [SAMPLE_BITS-1:0] smp,
    input  logic                          left_surv,
    input  logic                          right_vld,
    input  logic [AB-1:0]                 right_age,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    output logic                          vld_o,
    output logic [AB-1:0]                 age_o,
    output logic signed [SAMPLE_BITS-1:0] val_o,
    output logic                          surv_o,
    output logic                          expire_o,
    output logic signed [SAMPLE_BITS-1:0] val_next_o
);

    logic                          vld_reg;
    logic                          vld_next;
    logic [AB-1:0]                 age_reg;
    logic [AB-1:0]                 age_next;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;

    logic                          own_vld;
    logic [AB-1:0]                 own_age;
    logic                          rgt_vld;
    logic [AB-1:0]                 rgt_age;
    logic                          view_vld;
    logic [AB-1:0]                 view_age;
    logic signed [SAMPLE_BITS-1:0] view_val;
    logic                          surv;

    function automatic logic [AB-1:0] age_step(input logic [AB-1:0] a, input logic inc);
        if (inc && (a != AB'(MAX_WINDOW)))
        begin
            return a + AB'(1);
        end
        return a;
    endfunction

    always_comb
    begin
        own_vld  = vld_reg && !ctrl.clr;
        own_age  = age_step(age_reg, ctrl.inc);
        rgt_vld  = right_vld && !ctrl.clr;
        rgt_age  = age_step(right_age, ctrl.inc);

        view_vld = ctrl.sh ? rgt_vld : own_vld;
        view_age = ctrl.sh ? rgt_age : own_age;
        view_val = ctrl.sh ? right_val : val_reg;

        surv     = view_vld && (view_val > smp);

        vld_next = view_vld;
        age_next = view_age;
        val_next = view_val;
        if (ctrl.fin && !surv)
        begin
            // first slot past the survivors takes the new sample
            if (left_surv)
            begin
                vld_next = 1'b1;
                age_next = '0;
                val_next = smp;
            end
            else
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            age_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            age_reg <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign vld_o      = vld_reg;
    assign age_o      = age_reg;
    assign val_o      = val_reg;
    assign surv_o     = surv;
    assign expire_o   = own_vld && (KB'(own_age) >= k);
    assign val_next_o = val_next;

endmodule
